// ===== rtl/bpms_pkg.sv =====
package bpms_pkg;

   // default grid shape
   localparam int DEF_X_SIZE    = 16;
   localparam int DEF_TBAR_SIZE = 4;

   // fixed field widths of the channel words
   localparam int FUNC_W      = 2;
   localparam int ROW_FIELD_W = 2;
   localparam int COL_FIELD_W = 4;
   localparam int COEF_W      = 32;
   localparam int ACC_W       = 64;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD_L = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_R = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_MUL    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [ROW_FIELD_W-1:0]   row;
      logic [COL_FIELD_W-1:0]   col;
      logic signed [COEF_W-1:0] coef;
      logic signed [COEF_W-1:0] scale;
   } bpms_req_type;

   typedef struct packed {
      logic [ROW_FIELD_W-1:0]   out_row;
      logic [COL_FIELD_W-1:0]   out_col;
      logic signed [COEF_W-1:0] product_coef;
      logic [COL_FIELD_W-1:0]   x_degree;
      logic [ROW_FIELD_W-1:0]   row_degree;
      logic                     overflow;
      logic                     last;
   } bpms_rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_EVAL,
      ST_CHECK,
      ST_OVF,
      ST_CONV_RD,
      ST_CONV_MUL,
      ST_CONV_ACC,
      ST_RED_RD,
      ST_RED_MUL,
      ST_RED_WR,
      ST_EMIT_RD,
      ST_EMIT_LD
   } bpms_state_type;

   typedef enum logic [1:0] {
      ACC_ZERO,
      ACC_SUM,
      ACC_RES
   } bpms_acc_sel_type;

   typedef enum logic {
      MUL_CONV,
      MUL_SCALE
   } bpms_mul_sel_type;

   typedef struct packed {
      logic             op_wr_l;
      logic             op_wr_r;
      logic             op_wr_zero;
      logic             op_rd;
      logic             acc_rd;
      logic             acc_wr;
      bpms_acc_sel_type acc_sel;
      bpms_mul_sel_type mul_sel;
      logic             scale_load;
      logic             rsp_load;
      logic             rsp_ovf;
      logic             rsp_last;
   } bpms_ctrl_type;

   typedef struct packed {
      logic left_nz;
      logic right_nz;
      logic res_nz;
      logic rsp_free;
   } bpms_stat_type;

endpackage

// ===== rtl/bpms_if.sv =====
interface bpms_req_if
   import bpms_pkg::*;
();
   logic         valid;
   logic         ready;
   bpms_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bpms_rsp_if
   import bpms_pkg::*;
();
   logic         valid;
   logic         ready;
   bpms_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/bpms_mul.sv =====
module bpms_mul
   import bpms_pkg::*;
(
   input  logic                     clock,
   input  logic signed [COEF_W-1:0] mul_a,
   input  logic signed [COEF_W-1:0] mul_b,
   output logic signed [ACC_W-1:0]  mul_prod
);

   logic signed [ACC_W-1:0] prod_in;
   logic signed [ACC_W-1:0] prod_ff;

   // exact signed product, registered
   assign prod_in = ACC_W'(mul_a) * ACC_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

// ===== rtl/bpms_seq.sv =====
module bpms_seq
   import bpms_pkg::*;
#(
   parameter int X_SIZE = DEF_X_SIZE,
   parameter int TBAR_SIZE = DEF_TBAR_SIZE,
   localparam int COL_W = $clog2(X_SIZE),
   localparam int ROW_W = (TBAR_SIZE > 1) ? $clog2(TBAR_SIZE) : 1,
   localparam int ADDR_W = $clog2(X_SIZE * TBAR_SIZE)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [FUNC_W-1:0]      req_func,
   input  logic [ROW_FIELD_W-1:0] req_row,
   input  logic [COL_FIELD_W-1:0] req_col,
   output logic                   req_ready,
   input  bpms_stat_type          stat,
   output bpms_ctrl_type          ctrl,
   output logic [ADDR_W-1:0]      op_wr_addr,
   output logic [ADDR_W-1:0]      op_rd_addr_l,
   output logic [ADDR_W-1:0]      op_rd_addr_r,
   output logic [ADDR_W-1:0]      acc_addr,
   output logic [ROW_W-1:0]       rsp_row,
   output logic [COL_W-1:0]       rsp_col,
   output logic [COL_W-1:0]       rsp_x_deg,
   output logic [ROW_W-1:0]       rsp_t_deg
);

   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(TBAR_SIZE - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(X_SIZE - 1);

   bpms_state_type   state_ff, state_in;
   logic [ROW_W-1:0] r1_ff, r1_in, r2_ff, r2_in;
   logic [COL_W-1:0] m1_ff, m1_in, m2_ff, m2_in;
   logic [COL_W-1:0] ldx_ff, ldx_in, rdx_ff, rdx_in, pdx_ff, pdx_in;
   logic [ROW_W-1:0] ldt_ff, ldt_in, rdt_ff, rdt_in, pdt_ff, pdt_in;
   logic [ROW_W-1:0] walk_r;
   logic [COL_W-1:0] walk_m;
   logic             walk_end;
   logic             conv_end;
   logic             deg_ovf;
   logic             load_ok;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
      return ADDR_W'(int'(r) * X_SIZE + int'(c));
   endfunction

   assign walk_end = (r1_ff == ROW_LAST) && (m1_ff == COL_LAST);
   assign conv_end = (m2_ff == rdx_ff) && (r2_ff == rdt_ff) &&
                     (m1_ff == ldx_ff) && (r1_ff == ldt_ff);
   assign deg_ovf  = (int'(ldx_ff) + int'(rdx_ff) >= X_SIZE) ||
                     (int'(ldt_ff) + int'(rdt_ff) >= TBAR_SIZE);
   assign load_ok  = (int'(req_row) < TBAR_SIZE) && (int'(req_col) < X_SIZE);

   // row-major walk over the grid, wrapping to the origin at the end
   always_comb begin
      walk_r = r1_ff;
      walk_m = m1_ff;
      if (walk_end) begin
         walk_r = '0;
         walk_m = '0;
      end else if (m1_ff == COL_LAST) begin
         walk_r = r1_ff + 1'b1;
         walk_m = '0;
      end else begin
         walk_m = m1_ff + 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (walk_end) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_MUL) begin
                  state_in = ST_SCAN_RD;
               end else if (req_func == FUNC_CLEAR) begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_SCAN_RD:   state_in = ST_SCAN_EVAL;
         ST_SCAN_EVAL: state_in = walk_end ? ST_CHECK : ST_SCAN_RD;
         ST_CHECK:     state_in = deg_ovf ? ST_OVF : ST_CONV_RD;
         ST_OVF:       if (stat.rsp_free) state_in = ST_IDLE;
         ST_CONV_RD:   state_in = ST_CONV_MUL;
         ST_CONV_MUL:  state_in = ST_CONV_ACC;
         ST_CONV_ACC:  state_in = conv_end ? ST_RED_RD : ST_CONV_RD;
         ST_RED_RD:    state_in = ST_RED_MUL;
         ST_RED_MUL:   state_in = ST_RED_WR;
         ST_RED_WR:    state_in = walk_end ? ST_EMIT_RD : ST_RED_RD;
         ST_EMIT_RD:   state_in = ST_EMIT_LD;
         ST_EMIT_LD: begin
            if (stat.rsp_free) state_in = walk_end ? ST_IDLE : ST_EMIT_RD;
         end
         default:      state_in = ST_CLEAR;
      endcase
   end

   // counters and degrees
   always_comb begin
      r1_in  = r1_ff;
      m1_in  = m1_ff;
      r2_in  = r2_ff;
      m2_in  = m2_ff;
      ldx_in = ldx_ff;
      ldt_in = ldt_ff;
      rdx_in = rdx_ff;
      rdt_in = rdt_ff;
      pdx_in = pdx_ff;
      pdt_in = pdt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            r1_in  = '0;
            m1_in  = '0;
            r2_in  = '0;
            m2_in  = '0;
            ldx_in = '0;
            ldt_in = '0;
            rdx_in = '0;
            rdt_in = '0;
         end
         ST_CLEAR: begin
            r1_in = walk_r;
            m1_in = walk_m;
         end
         ST_SCAN_EVAL: begin
            r1_in = walk_r;
            m1_in = walk_m;
            if (stat.left_nz) begin
               ldt_in = r1_ff;
               if (m1_ff > ldx_ff) ldx_in = m1_ff;
            end
            if (stat.right_nz) begin
               rdt_in = r1_ff;
               if (m1_ff > rdx_ff) rdx_in = m1_ff;
            end
         end
         ST_CHECK: begin
            pdx_in = '0;
            pdt_in = '0;
         end
         ST_CONV_ACC: begin
            // nested walk: right column, right row, left column, left row
            if (m2_ff != rdx_ff) begin
               m2_in = m2_ff + 1'b1;
            end else begin
               m2_in = '0;
               if (r2_ff != rdt_ff) begin
                  r2_in = r2_ff + 1'b1;
               end else begin
                  r2_in = '0;
                  if (m1_ff != ldx_ff) begin
                     m1_in = m1_ff + 1'b1;
                  end else begin
                     m1_in = '0;
                     r1_in = (r1_ff != ldt_ff) ? r1_ff + 1'b1 : '0;
                  end
               end
            end
         end
         ST_RED_WR: begin
            r1_in = walk_r;
            m1_in = walk_m;
            if (stat.res_nz) begin
               pdt_in = r1_ff;
               if (m1_ff > pdx_ff) pdx_in = m1_ff;
            end
         end
         ST_EMIT_LD: begin
            if (stat.rsp_free) begin
               r1_in = walk_r;
               m1_in = walk_m;
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      ctrl         = '0;
      ctrl.acc_sel = ACC_ZERO;
      ctrl.mul_sel = MUL_CONV;
      op_wr_addr   = addr_of(r1_ff, m1_ff);
      op_rd_addr_l = addr_of(r1_ff, m1_ff);
      op_rd_addr_r = addr_of(r2_ff, m2_ff);
      acc_addr     = addr_of(r1_ff, m1_ff);
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.op_wr_l    = 1'b1;
            ctrl.op_wr_r    = 1'b1;
            ctrl.op_wr_zero = 1'b1;
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            op_wr_addr = ADDR_W'(int'(req_row) * X_SIZE + int'(req_col));
            if (req_valid) begin
               ctrl.op_wr_l    = (req_func == FUNC_LOAD_L) && load_ok;
               ctrl.op_wr_r    = (req_func == FUNC_LOAD_R) && load_ok;
               ctrl.scale_load = (req_func == FUNC_MUL);
            end
         end
         ST_SCAN_RD: begin
            // read both operands at the same place, clear the accumulator there
            ctrl.op_rd   = 1'b1;
            op_rd_addr_r = addr_of(r1_ff, m1_ff);
            ctrl.acc_wr  = 1'b1;
            ctrl.acc_sel = ACC_ZERO;
         end
         ST_OVF: begin
            ctrl.rsp_load = stat.rsp_free;
            ctrl.rsp_ovf  = 1'b1;
            ctrl.rsp_last = 1'b1;
         end
         ST_CONV_RD: begin
            ctrl.op_rd  = 1'b1;
            ctrl.acc_rd = 1'b1;
            acc_addr    = addr_of(ROW_W'(r1_ff + r2_ff), COL_W'(m1_ff + m2_ff));
         end
         ST_CONV_MUL: begin
            ctrl.mul_sel = MUL_CONV;
            acc_addr     = addr_of(ROW_W'(r1_ff + r2_ff), COL_W'(m1_ff + m2_ff));
         end
         ST_CONV_ACC: begin
            ctrl.acc_wr  = 1'b1;
            ctrl.acc_sel = ACC_SUM;
            acc_addr     = addr_of(ROW_W'(r1_ff + r2_ff), COL_W'(m1_ff + m2_ff));
         end
         ST_RED_RD:   ctrl.acc_rd = 1'b1;
         ST_RED_MUL:  ctrl.mul_sel = MUL_SCALE;
         ST_RED_WR: begin
            ctrl.acc_wr  = 1'b1;
            ctrl.acc_sel = ACC_RES;
         end
         ST_EMIT_RD:  ctrl.acc_rd = 1'b1;
         ST_EMIT_LD: begin
            ctrl.rsp_load = stat.rsp_free;
            ctrl.rsp_last = walk_end;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         r1_ff    <= '0;
         m1_ff    <= '0;
         r2_ff    <= '0;
         m2_ff    <= '0;
      end else begin
         state_ff <= state_in;
         r1_ff    <= r1_in;
         m1_ff    <= m1_in;
         r2_ff    <= r2_in;
         m2_ff    <= m2_in;
      end
   end

   always_ff @(posedge clock) begin
      ldx_ff <= ldx_in;
      ldt_ff <= ldt_in;
      rdx_ff <= rdx_in;
      rdt_ff <= rdt_in;
      pdx_ff <= pdx_in;
      pdt_ff <= pdt_in;
   end

   assign rsp_row   = r1_ff;
   assign rsp_col   = m1_ff;
   assign rsp_x_deg = pdx_ff;
   assign rsp_t_deg = pdt_ff;

endmodule

// ===== rtl/bivariate_poly_multiply_scaled_unit.sv =====
// Bivariate polynomial multiplier with scaling. Two operand grids of TBAR_SIZE rows (tbar
// powers) by X_SIZE columns (x powers) of signed Q16.16 coefficients are loaded one word at
// a time; a multiply word convolves them, scales the product by its Q16.16 scale and returns
// all TBAR_SIZE*X_SIZE coefficients in row-major order with the product degrees, or a single
// overflow word when a degree sum leaves the grid. A clear zeroes both grids, and after
// reset the same clearing pass runs before the first word is taken. A multiply scans both
// grids for their degrees, checks the degree sums, then reads, multiplies and accumulates
// each coefficient pair (pairs = (ltd+1)(lxd+1)(rtd+1)(rxd+1)), reduces and scales every
// cell and emits the result words, stalling while the sink is not ready. The pair and reduce
// loops share the one 32x32 multiplier and the single-port accumulator memory. Only one word
// is in flight at a time.
module bivariate_poly_multiply_scaled_unit
   import bpms_pkg::*;
#(
   parameter int X_SIZE = DEF_X_SIZE,
   parameter int TBAR_SIZE = DEF_TBAR_SIZE
) (
   input logic        clock,
   input logic        reset,
   bpms_req_if.sink   req_if,
   bpms_rsp_if.source rsp_if
);

   localparam int GRID   = X_SIZE * TBAR_SIZE;
   localparam int ADDR_W = $clog2(GRID);
   localparam int COL_W  = $clog2(X_SIZE);
   localparam int ROW_W  = (TBAR_SIZE > 1) ? $clog2(TBAR_SIZE) : 1;

   localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

   logic          req_valid;
   logic          req_ready;
   bpms_req_type  req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   bpms_ctrl_type ctrl;
   bpms_stat_type stat;

   logic [ADDR_W-1:0] op_wr_addr, op_rd_addr_l, op_rd_addr_r, acc_addr;
   logic [ROW_W-1:0]  rsp_row, rsp_t_deg;
   logic [COL_W-1:0]  rsp_col, rsp_x_deg;

   logic signed [COEF_W-1:0] left_mem [GRID];
   logic signed [COEF_W-1:0] right_mem [GRID];
   logic signed [ACC_W-1:0]  acc_mem [GRID];

   logic signed [COEF_W-1:0] left_rd_ff, right_rd_ff, scale_ff;
   logic signed [ACC_W-1:0]  acc_rd_ff;
   logic signed [COEF_W-1:0] op_wr_data;
   logic signed [ACC_W-1:0]  acc_wr_data;
   logic signed [COEF_W-1:0] mul_a, mul_b, res;
   logic signed [ACC_W-1:0]  mul_prod;
   logic                     rsp_valid_ff, rsp_valid_in;
   bpms_rsp_type             rsp_data_ff, rsp_data_in;

   // arithmetic shift right by 16, then saturate to 32 bits
   function automatic logic signed [COEF_W-1:0] sat_shr16(input logic signed [ACC_W-1:0] x);
      if (x[ACC_W-1:47] == {(ACC_W-47){x[ACC_W-1]}}) begin
         return x[47:16];
      end
      return x[ACC_W-1] ? COEF_MIN : COEF_MAX;
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? ACC_MIN : ACC_MAX;
      end
      return s[ACC_W-1:0];
   endfunction

   assign req_valid     = req_if.valid;
   assign req_data      = req_if.payload;
   assign req_if.ready  = req_ready;
   assign rsp_ready     = rsp_if.ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_if.valid  = rsp_valid;
   assign rsp_if.payload = rsp_data_ff;

   bpms_seq #(
      .X_SIZE    (X_SIZE),
      .TBAR_SIZE (TBAR_SIZE)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_func     (req_data.func),
      .req_row      (req_data.row),
      .req_col      (req_data.col),
      .req_ready    (req_ready),
      .stat         (stat),
      .ctrl         (ctrl),
      .op_wr_addr   (op_wr_addr),
      .op_rd_addr_l (op_rd_addr_l),
      .op_rd_addr_r (op_rd_addr_r),
      .acc_addr     (acc_addr),
      .rsp_row      (rsp_row),
      .rsp_col      (rsp_col),
      .rsp_x_deg    (rsp_x_deg),
      .rsp_t_deg    (rsp_t_deg)
   );

   assign mul_a = (ctrl.mul_sel == MUL_SCALE) ? sat_shr16(acc_rd_ff) : left_rd_ff;
   assign mul_b = (ctrl.mul_sel == MUL_SCALE) ? scale_ff : right_rd_ff;

   bpms_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   assign res        = sat_shr16(mul_prod);
   assign op_wr_data = ctrl.op_wr_zero ? '0 : req_data.coef;

   always_comb begin
      unique case (ctrl.acc_sel)
         ACC_ZERO: acc_wr_data = '0;
         ACC_SUM:  acc_wr_data = sat_add(acc_rd_ff, mul_prod);
         ACC_RES:  acc_wr_data = {{(ACC_W-COEF_W){res[COEF_W-1]}}, res};
         default:  acc_wr_data = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.op_wr_l) left_mem[op_wr_addr] <= op_wr_data;
      if (ctrl.op_rd) left_rd_ff <= left_mem[op_rd_addr_l];
   end

   always_ff @(posedge clock) begin
      if (ctrl.op_wr_r) right_mem[op_wr_addr] <= op_wr_data;
      if (ctrl.op_rd) right_rd_ff <= right_mem[op_rd_addr_r];
   end

   always_ff @(posedge clock) begin
      if (ctrl.acc_wr) acc_mem[acc_addr] <= acc_wr_data;
      if (ctrl.acc_rd) acc_rd_ff <= acc_mem[acc_addr];
   end

   always_ff @(posedge clock) begin
      if (ctrl.scale_load) scale_ff <= req_data.scale;
   end

   assign stat.left_nz  = (left_rd_ff != '0);
   assign stat.right_nz = (right_rd_ff != '0);
   assign stat.res_nz   = (res != '0);
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   // output word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (ctrl.rsp_ovf) begin
            rsp_data_in.overflow = 1'b1;
            rsp_data_in.last     = 1'b1;
         end else begin
            rsp_data_in.out_row      = ROW_FIELD_W'(rsp_row);
            rsp_data_in.out_col      = COL_FIELD_W'(rsp_col);
            rsp_data_in.product_coef = acc_rd_ff[COEF_W-1:0];
            rsp_data_in.x_degree     = COL_FIELD_W'(rsp_x_deg);
            rsp_data_in.row_degree   = ROW_FIELD_W'(rsp_t_deg);
            rsp_data_in.last         = ctrl.rsp_last;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/bpms_check.sv =====
module bpms_check
   import bpms_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [FUNC_W-1:0] req_func,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bpms_rsp_type      rsp_data
);

   // the clearing pass holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

   // a load leaves the block ready again in the next cycle
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_LOAD_L || req_func == FUNC_LOAD_R)
      |=> req_ready)
      else $error("load did not return to ready");

   // no new request while a product run is still emitting
   a_no_req_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> !req_ready)
      else $error("request taken in the middle of a run");

   // an overflow word is a lone, empty, final word
   a_ovf_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |->
         rsp_data.last && rsp_data.product_coef == '0 &&
         rsp_data.x_degree == '0 && rsp_data.row_degree == '0)
      else $error("malformed overflow word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

endmodule

bind bivariate_poly_multiply_scaled_unit bpms_check u_bpms_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_func  (req_data.func),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data_ff)
);

// ===== tb/bpms_tb_pkg.sv =====
`timescale 1ns / 1ps

package bpms_tb_pkg;
   import bpms_pkg::*;

   localparam int GRID_W = DEF_X_SIZE * DEF_TBAR_SIZE;
   localparam int MAX_REPORTS = 50;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef logic signed [COEF_W-1:0] coef_grid_type [GRID_W];

   // Keeps its own copy of both operand grids and turns every multiply word into the
   // queue of coefficient words the block should return.
   class poly_product_calc;
      coef_grid_type left_grid;
      coef_grid_type right_grid;
      bpms_rsp_type  awaited[$];
      int errors;
      int checked;
      int loads;
      int clears;
      int products;
      int overflows;

      function new();
         wipe_operands();
      endfunction

      function void wipe_operands();
         foreach (left_grid[i]) begin
            left_grid[i] = '0;
            right_grid[i] = '0;
         end
      endfunction

      function logic signed [COEF_W-1:0] clamp_q16(logic signed [ACC_W-1:0] v);
         if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[COEF_W-1:0];
      endfunction

      function void grid_degrees(input coef_grid_type g, output int dx, output int dt);
         dx = 0;
         dt = 0;
         for (int r = 0; r < DEF_TBAR_SIZE; r++)
            for (int m = 0; m < DEF_X_SIZE; m++)
               if (g[r*DEF_X_SIZE + m] != 0) begin
                  if (m > dx) dx = m;
                  if (r > dt) dt = r;
               end
      endfunction

      function void form_product(logic signed [COEF_W-1:0] scale);
         logic signed [ACC_W-1:0] acc [GRID_W];
         coef_grid_type           res;
         logic signed [ACC_W-1:0] lw;
         logic signed [ACC_W-1:0] rw;
         logic signed [ACC_W-1:0] pair;
         logic signed [ACC_W:0]   wide;
         logic signed [COEF_W-1:0] reduced;
         bpms_rsp_type            word;
         int ldx, ldt, rdx, rdt, pdx, pdt, idx;

         products++;
         grid_degrees(left_grid, ldx, ldt);
         grid_degrees(right_grid, rdx, rdt);
         word = '0;
         if (ldx + rdx >= DEF_X_SIZE || ldt + rdt >= DEF_TBAR_SIZE) begin
            overflows++;
            word.overflow = 1'b1;
            word.last = 1'b1;
            awaited.push_back(word);
            return;
         end

         foreach (acc[i]) acc[i] = '0;
         for (int r1 = 0; r1 <= ldt; r1++)
            for (int m1 = 0; m1 <= ldx; m1++)
               for (int r2 = 0; r2 <= rdt; r2++)
                  for (int m2 = 0; m2 <= rdx; m2++) begin
                     idx = (r1 + r2) * DEF_X_SIZE + m1 + m2;
                     lw = left_grid[r1*DEF_X_SIZE + m1];
                     rw = right_grid[r2*DEF_X_SIZE + m2];
                     pair = lw * rw;
                     // one extra bit catches the wrap; clamp at the 64-bit limits
                     wide = {acc[idx][ACC_W-1], acc[idx]} + {pair[ACC_W-1], pair};
                     if (wide[ACC_W] != wide[ACC_W-1])
                        acc[idx] = wide[ACC_W] ? ACC_MIN : ACC_MAX;
                     else
                        acc[idx] = wide[ACC_W-1:0];
                  end

         foreach (res[i]) begin
            reduced = clamp_q16(acc[i] >>> 16);
            lw = reduced;
            rw = scale;
            res[i] = clamp_q16((lw * rw) >>> 16);
         end
         grid_degrees(res, pdx, pdt);

         for (int r = 0; r < DEF_TBAR_SIZE; r++)
            for (int m = 0; m < DEF_X_SIZE; m++) begin
               word.out_row = ROW_FIELD_W'(r);
               word.out_col = COL_FIELD_W'(m);
               word.product_coef = res[r*DEF_X_SIZE + m];
               word.x_degree = COL_FIELD_W'(pdx);
               word.row_degree = ROW_FIELD_W'(pdt);
               word.overflow = 1'b0;
               word.last = (r*DEF_X_SIZE + m == GRID_W - 1);
               awaited.push_back(word);
            end
      endfunction

      function void take_request(bpms_req_type w);
         int idx;
         case (w.func)
            FUNC_LOAD_L, FUNC_LOAD_R: begin
               loads++;
               if (w.row < DEF_TBAR_SIZE && w.col < DEF_X_SIZE) begin
                  idx = w.row * DEF_X_SIZE + w.col;
                  if (w.func == FUNC_LOAD_L) left_grid[idx] = w.coef;
                  else right_grid[idx] = w.coef;
               end
            end
            FUNC_MUL: form_product(w.scale);
            FUNC_CLEAR: begin
               clears++;
               wipe_operands();
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
      endtask

      task compare_field(string name, logic [COEF_W-1:0] got, logic [COEF_W-1:0] want,
                         bpms_rsp_type ref_word);
         if (got !== want)
            report_mismatch($sformatf("result %0d (row %0d col %0d) %s: got %h, expected %h",
                                      checked, ref_word.out_row, ref_word.out_col, name,
                                      got, want));
      endtask

      task match_word(bpms_rsp_type got);
         bpms_rsp_type want;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("result word %h arrived with nothing pending", got));
            return;
         end
         want = awaited.pop_front();
         checked++;
         compare_field("out_row", got.out_row, want.out_row, want);
         compare_field("out_col", got.out_col, want.out_col, want);
         compare_field("product_coef", got.product_coef, want.product_coef, want);
         compare_field("x_degree", got.x_degree, want.x_degree, want);
         compare_field("row_degree", got.row_degree, want.row_degree, want);
         compare_field("overflow", got.overflow, want.overflow, want);
         compare_field("last", got.last, want.last, want);
      endtask
   endclass

endpackage

// ===== tb/bivariate_poly_multiply_scaled_unit_tb.sv =====
`timescale 1ns / 1ps

module bivariate_poly_multiply_scaled_unit_tb;
   import bpms_pkg::*;
   import bpms_tb_pkg::*;

   localparam int CLOCK_HALF = 4;
   localparam int RESET_CYCLES = 12;
   localparam int IDLE_LIMIT = 10000;
   localparam int TAIL_CYCLES = 400;
   localparam int TARGET_WORDS = 380;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpms_req_if req_bus ();
   bpms_rsp_if rsp_bus ();

   bivariate_poly_multiply_scaled_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   poly_product_calc poly_mult = new();

   int words_sent = 0;
   int idle_cycles = 0;
   int send_calm = 0;
   int recv_calm = 0;
   int recv_wait = 0;

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Mostly a random wait per word, now and then a run of back-to-back words.
   function automatic int draw_wait(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 11) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 7))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return $urandom_range(0, 32'h7FFFF) - 32'h3FFFF;
         4: return ($urandom_range(0, 8) - 32'd4) << 16;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] pick_scale();
      case ($urandom_range(0, 7))
         0: return 32'h00010000;
         1: return 32'h7FFFFFFF;
         2: return 32'h80000000;
         3: return 32'h0;
         4: return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
         5: return 32'hFFFFFFFF;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_word(logic [FUNC_W-1:0] func, int row, int col,
                            logic [COEF_W-1:0] coef, logic [COEF_W-1:0] scale);
      bpms_req_type w;
      int gap;
      w.func = func;
      w.row = ROW_FIELD_W'(row);
      w.col = COL_FIELD_W'(col);
      w.coef = coef;
      w.scale = scale;
      gap = draw_wait(send_calm);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.payload <= w;
      req_bus.valid <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      poly_mult.take_request(w);
      words_sent++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (poly_mult.awaited.size() != 0) @(posedge clock);
   endtask

   // Fill random cells inside the degree box, then pin the corner so the degrees hold.
   task automatic load_operand(logic [FUNC_W-1:0] func, int dt, int dx);
      logic [COEF_W-1:0] pin;
      repeat ($urandom_range(0, 5))
         send_word(func, $urandom_range(0, dt), $urandom_range(0, dx), pick_coef(),
                   $urandom());
      do pin = pick_coef(); while (pin == 0);
      send_word(func, dt, dx, pin, $urandom());
   endtask

   task automatic run_product_sequence(bit spill);
      int ldx, ldt, rdx, rdt;
      if ($urandom_range(0, 6) != 0)
         send_word(FUNC_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
      if (spill && $urandom_range(0, 1) == 1) begin
         // x degrees sum past the grid
         ldx = $urandom_range(1, DEF_X_SIZE - 1);
         rdx = $urandom_range(DEF_X_SIZE - ldx, DEF_X_SIZE - 1);
         ldt = $urandom_range(0, DEF_TBAR_SIZE - 1);
         rdt = $urandom_range(0, DEF_TBAR_SIZE - 1 - ldt);
      end else if (spill) begin
         ldt = $urandom_range(1, DEF_TBAR_SIZE - 1);
         rdt = $urandom_range(DEF_TBAR_SIZE - ldt, DEF_TBAR_SIZE - 1);
         ldx = $urandom_range(0, DEF_X_SIZE - 1);
         rdx = $urandom_range(0, DEF_X_SIZE - 1 - ldx);
      end else begin
         ldx = $urandom_range(0, DEF_X_SIZE - 1);
         rdx = $urandom_range(0, DEF_X_SIZE - 1 - ldx);
         ldt = $urandom_range(0, DEF_TBAR_SIZE - 1);
         rdt = $urandom_range(0, DEF_TBAR_SIZE - 1 - ldt);
      end
      load_operand(FUNC_LOAD_L, ldt, ldx);
      load_operand(FUNC_LOAD_R, rdt, rdx);
      send_word(FUNC_MUL, $urandom(), $urandom(), $urandom(), pick_scale());
   endtask

   task automatic run_noise();
      logic [FUNC_W-1:0] f;
      repeat ($urandom_range(3, 8)) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: f = FUNC_LOAD_L;
            4, 5, 6, 7: f = FUNC_LOAD_R;
            8: f = FUNC_MUL;
            default: f = FUNC_CLEAR;
         endcase
         send_word(f, $urandom(), $urandom(), pick_coef(), pick_scale());
      end
   endtask

   // result side: hold ready low for a drawn number of cycles after each word
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_wait > 0) begin
            rsp_bus.ready <= 1'b0;
            recv_wait--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         poly_mult.match_word(rsp_bus.payload);
         recv_wait = draw_wait(recv_calm);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no word moved on either channel for %0d cycles", idle_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int pick;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // accumulator saturation: two most-negative pairs land on the same cell
      send_word(FUNC_LOAD_L, 0, 0, 32'h80000000, 32'h0);
      send_word(FUNC_LOAD_L, 0, 1, 32'h80000000, 32'h0);
      send_word(FUNC_LOAD_R, 0, 0, 32'h80000000, 32'h0);
      send_word(FUNC_LOAD_R, 0, 1, 32'h80000000, 32'h0);
      send_word(FUNC_MUL, 0, 0, 32'h0, 32'h7FFFFFFF);
      send_word(FUNC_MUL, 0, 0, 32'h0, 32'h80000000);
      send_word(FUNC_LOAD_L, 0, 0, 32'h7FFFFFFF, 32'h0);
      send_word(FUNC_MUL, 0, 0, 32'h0, 32'h0);
      // cleared operands give an all-zero product
      send_word(FUNC_CLEAR, 3, 15, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_word(FUNC_MUL, 0, 0, 32'h0, 32'h00010000);
      // x degree sum leaves the grid
      send_word(FUNC_LOAD_L, 0, 15, 32'h00010000, 32'h0);
      send_word(FUNC_LOAD_R, 0, 1, 32'h00010000, 32'h0);
      send_word(FUNC_MUL, 0, 0, 32'h0, 32'h00010000);
      // tbar degree sum leaves the grid
      send_word(FUNC_CLEAR, 0, 0, 32'h0, 32'h0);
      send_word(FUNC_LOAD_L, 3, 0, 32'h00020000, 32'h0);
      send_word(FUNC_LOAD_R, 1, 0, 32'hFFFF0000, 32'h0);
      send_word(FUNC_MUL, 0, 0, 32'h0, 32'h00010000);
      // overwrite with zero drops the right degree back to zero
      send_word(FUNC_LOAD_R, 1, 0, 32'h0, 32'h0);
      send_word(FUNC_LOAD_R, 0, 0, 32'h00018000, 32'h0);
      send_word(FUNC_LOAD_L, 3, 15, 32'hFFFF8000, 32'h0);
      send_word(FUNC_MUL, 0, 0, 32'h0, 32'h00010000);
      send_word(FUNC_MUL, 0, 0, 32'h0, 32'hFFFFFFFF);
      hold_until_drained();

      while (words_sent < TARGET_WORDS) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) run_product_sequence(1'b0);
         else if (pick < 8) run_product_sequence(1'b1);
         else run_noise();
         if ($urandom_range(0, 7) == 0) hold_until_drained();
      end
      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d request words: %0d loads, %0d clears, %0d multiplies (%0d overflowed).",
               words_sent, poly_mult.loads, poly_mult.clears, poly_mult.products,
               poly_mult.overflows);
      $display("Checked %0d result words, %0d mismatches.", poly_mult.checked,
               poly_mult.errors);
      if (poly_mult.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
